@@ rtl/core/ibc_pkg.sv @@
// ----------------------------------------------------------------------------
// Instruction block cache package
// Shared sizes, command and status codes, queue entry type, block-end decode.
// ----------------------------------------------------------------------------
package ibc_pkg;

  localparam int IndexBits  = 7;
  localparam int BlockWords = 24;
  localparam int NumEntries = 1 << IndexBits;
  localparam int PosBits    = $clog2(BlockWords + 1);
  localparam int WordAddrBits = $clog2(NumEntries * BlockWords);

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_INVAL  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_INVAL   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] length;
    logic [15:0] fill_word;
  } cmd_t;

  function automatic logic ends_block(input logic [15:0] w);
    logic [3:0] nib;
    logic [7:0] hi;
    nib = w[15:12];
    hi  = w[15:8];
    ends_block = (nib == 4'hA) || (nib == 4'hB) ||
                 (hi == 8'h89) || (hi == 8'h8B) || (hi == 8'h8D) ||
                 (hi == 8'h8F) || (hi == 8'hC3) ||
                 (w == 16'h402B) || (w == 16'h400B) || (w == 16'h000B) ||
                 (w == 16'h002B) || (w == 16'h0023) || (w == 16'h0003);
  endfunction

endpackage

@@ rtl/core/ibc_front.sv @@
// ----------------------------------------------------------------------------
// Instruction block cache front end
// Accepts commands, drops unused kinds, and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module ibc_front import ibc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  cmd_t        cmd_in,
  output logic        busy,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       fifo_r [2];
  logic [1:0] count_r, count_nxt;
  logic       rd_r, rd_nxt;
  logic       push;

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy && (cmd_in.kind != KIND_NONE);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = fifo_r[rd_r];

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(q_pop);
    rd_nxt    = rd_r ^ q_pop;
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[rd_r ^ count_r[0]] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
    end
  end

endmodule

@@ rtl/core/ibc_back.sv @@
// ----------------------------------------------------------------------------
// Instruction block cache back end
// Executes lookups, fills and invalidate sweeps against the entry store.
// ----------------------------------------------------------------------------
module ibc_back import ibc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_op_word,
  output logic [4:0]  out_op_index,
  output logic        out_last,
  output logic [31:0] out_fetch_address
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAG  = 2'd1;
  localparam logic [1:0] S_HIT  = 2'd2;
  localparam logic [1:0] S_INV  = 2'd3;

  logic [31:0]        tag_mem [NumEntries];
  logic [PosBits-1:0] len_mem [NumEntries];
  logic [15:0]        word_mem [NumEntries * BlockWords];
  logic [NumEntries-1:0] valid_r;

  logic [1:0]           state_r;
  cmd_t                 cmd_r;
  logic [IndexBits-1:0] idx_r;
  logic [31:0]          tag_q;
  logic [PosBits-1:0]   len_q;
  logic [15:0]          word_q;
  logic [PosBits-1:0]   pos_r;
  logic                 word_pend_r;
  logic [IndexBits:0]   sweep_r;
  logic [12:0]          first_r, lastp_r;

  logic                 fill_active_r;
  logic [31:0]          fill_start_r;
  logic [PosBits-1:0]   fill_pos_r;

  logic [IndexBits-1:0] fill_idx;
  logic [PosBits-1:0]   fpos, fpos_inc;
  logic                 fclose;
  logic [31:0]          waddr_calc;
  logic [WordAddrBits-1:0] fill_waddr, rd_waddr;
  logic [IndexBits-1:0] lk_idx;
  logic [IndexBits-1:0] sw_idx;
  logic [12:0]          pg;

  assign fill_idx = fill_start_r[IndexBits:1];
  assign fpos     = (fill_pos_r >= PosBits'(BlockWords)) ?
                    PosBits'(BlockWords - 1) : fill_pos_r;
  assign fpos_inc = fpos + 1'b1;
  assign fclose   = ends_block(q_cmd.fill_word) || (fpos_inc >= PosBits'(BlockWords));
  assign fill_waddr = WordAddrBits'(fill_idx * BlockWords) + WordAddrBits'(fpos);
  assign rd_waddr   = WordAddrBits'(idx_r * BlockWords) + WordAddrBits'(pos_r);
  assign lk_idx   = q_cmd.address[IndexBits:1];
  assign sw_idx   = sweep_r[IndexBits-1:0];
  assign pg       = tag_q[31:19];
  assign waddr_calc = fill_start_r + {26'd0, fpos_inc, 1'b0};

  assign q_pop = q_valid && (state_r == S_IDLE) &&
                 (q_cmd.kind == KIND_FILL || q_cmd.kind == KIND_LOOKUP ||
                  q_cmd.kind == KIND_INVAL);

  // tag and length reads, registered; hold the length for the whole hit
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[(state_r == S_INV) ? sw_idx : lk_idx];
    if (state_r == S_IDLE) len_q <= len_mem[lk_idx];
    word_q <= word_mem[rd_waddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == KIND_FILL && fill_active_r) begin
      word_mem[fill_waddr] <= q_cmd.fill_word;
      if (fclose) begin
        tag_mem[fill_idx] <= fill_start_r;
        len_mem[fill_idx] <= fpos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      fill_active_r <= 1'b0;
      fill_start_r  <= '0;
      fill_pos_r    <= '0;
      out_valid     <= 1'b0;
      word_pend_r   <= 1'b0;
    end else begin
      out_valid   <= 1'b0;
      word_pend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            idx_r <= lk_idx;
            unique case (q_cmd.kind)
              KIND_LOOKUP: begin
                fill_active_r <= 1'b0;
                state_r       <= S_TAG;
              end
              KIND_FILL: begin
                out_valid    <= 1'b1;
                out_op_word  <= q_cmd.fill_word;
                if (!fill_active_r) begin
                  out_status        <= ST_IGNORED;
                  out_op_index      <= '0;
                  out_last          <= 1'b0;
                  out_fetch_address <= '0;
                end else begin
                  out_status   <= ST_FILL;
                  out_op_index <= 5'(fpos);
                  fill_pos_r   <= fpos_inc;
                  if (fclose) begin
                    valid_r[fill_idx] <= 1'b1;
                    fill_active_r     <= 1'b0;
                    out_last          <= 1'b1;
                    out_fetch_address <= '0;
                  end else begin
                    out_last          <= 1'b0;
                    out_fetch_address <= waddr_calc;
                  end
                end
              end
              default: begin
                first_r <= q_cmd.address[31:19];
                lastp_r <= 13'((q_cmd.address + q_cmd.length) >> 19);
                sweep_r <= '0;
                state_r <= S_INV;
              end
            endcase
          end
        end
        S_TAG: begin
          if (valid_r[idx_r] && tag_q == cmd_r.address && len_q != '0) begin
            pos_r   <= '0;
            state_r <= S_HIT;
          end else begin
            valid_r[idx_r]    <= 1'b0;
            fill_active_r     <= 1'b1;
            fill_start_r      <= cmd_r.address;
            fill_pos_r        <= '0;
            out_valid         <= 1'b1;
            out_status        <= ST_MISS;
            out_op_word       <= '0;
            out_op_index      <= '0;
            out_last          <= 1'b0;
            out_fetch_address <= cmd_r.address;
            state_r           <= S_IDLE;
          end
        end
        S_HIT: begin
          // word read issued last cycle; emit it only once word_pend_r is set, then step pos_r
          if (!word_pend_r) begin
            word_pend_r <= 1'b1;
          end else begin
            out_valid         <= 1'b1;
            out_status        <= ST_HIT;
            out_op_word       <= word_q;
            out_op_index      <= 5'(pos_r);
            out_last          <= (pos_r + 1'b1 == len_q);
            out_fetch_address <= '0;
            if (pos_r + 1'b1 == len_q) state_r <= S_IDLE;
            else pos_r <= pos_r + 1'b1;
          end
        end
        default: begin
          // tag read for entry sweep_r lands next cycle; check the previous one
          if (sweep_r != '0) begin
            if (valid_r[sw_idx - 1'b1] && pg >= first_r && pg <= lastp_r)
              valid_r[sw_idx - 1'b1] <= 1'b0;
          end
          if (sweep_r == (IndexBits+1)'(NumEntries)) begin
            out_valid         <= 1'b1;
            out_status        <= ST_INVAL;
            out_op_word       <= '0;
            out_op_index      <= '0;
            out_last          <= 1'b0;
            out_fetch_address <= '0;
            state_r           <= S_IDLE;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/core/instruction_block_cache_unit.sv @@
// A lookup reads the tag first; a hit then streams the block words in order and a
// miss reports the fetch address; a fill word is written and reported at once;
// invalidate sweeps the 128-entry tag memory, one entry per cycle.
// Commands run one at a time; busy rises only when the two-deep queue is full.
// Reset (rst_n low, synchronous) clears all valid bits and the fill state at once.
// The receiver cannot stall; each result appears for one cycle with out_valid.
// ----------------------------------------------------------------------------
// Instruction block cache top level
// Joins the command front end and the execution back end.
// ----------------------------------------------------------------------------
module instruction_block_cache_unit import ibc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  input  logic [31:0] in_length,
  input  logic [15:0] in_fill_word,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_op_word,
  output logic [4:0]  out_op_index,
  output logic        out_last,
  output logic [31:0] out_fetch_address
);

  cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;

  assign cmd_in = '{kind: in_kind, address: in_address, length: in_length,
                    fill_word: in_fill_word};

  ibc_front u_front (
    .clk, .rst_n, .start, .cmd_in, .busy, .q_valid, .q_cmd, .q_pop
  );

  ibc_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_status,
    .out_op_word, .out_op_index, .out_last, .out_fetch_address
  );

endmodule

@@ rtl/core/ibc_checker.sv @@
// ----------------------------------------------------------------------------
// Instruction block cache port checker
// Watches the top-level ports for result encoding rules.
// ----------------------------------------------------------------------------
module ibc_checker import ibc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic        out_last,
  input logic [31:0] out_fetch_address
);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_IGNORED))
    else $error("bad status");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_status == ST_HIT || out_status == ST_FILL))
    else $error("last on wrong status");

  a_hit_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_HIT || out_status == ST_INVAL))
      |-> (out_fetch_address == '0))
    else $error("fetch address not zero");

endmodule

bind instruction_block_cache_unit ibc_checker u_ibc_checker (
  .clk, .rst_n, .out_valid, .out_status, .out_last, .out_fetch_address
);
